### sv/adaline_pkg.sv
// Package for the ADALINE LMS update block: sizes, fixed-point constants,
// multiplier operation tags. No dependencies.
package adaline_pkg;

    localparam int IN_DIM  = 4;
    localparam int OUT_DIM = 2;

    localparam int DATA_W = 24;
    localparam int X_W    = 16;
    localparam int RATE_W = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'd655;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam int IDX_W = (IN_DIM > 1) ? $clog2(IN_DIM) : 1;
    localparam int N_W   = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;

    // shared multiplier: signed MA_W x signed MB_W
    localparam int MA_W   = DATA_W + 1;
    localparam int MB_W   = X_W + 1;
    localparam int PROD_W = MA_W + MB_W;

    localparam int WX_W  = DATA_W + X_W;
    localparam int ACC_W = WX_W + $clog2(IN_DIM + 1);

    // rate * error, split into halves for the weight step
    localparam int P_W  = DATA_W + RATE_W;
    localparam int PL_W = P_W / 2;
    localparam int PH_W = P_W - PL_W;

    localparam int ACCU_W = P_W + X_W + 1;

    localparam int Y_SHIFT = 12;
    localparam int W_SHIFT = 27;
    localparam int B_SHIFT = 15;

    localparam int SAT_W = ACC_W + 1;

    typedef enum logic [1:0] {
        OP_MAC,
        OP_RE,
        OP_LO,
        OP_HI
    } op_t;

    typedef struct packed {
        logic             vld;
        op_t              op;
        logic [N_W-1:0]   n;
        logic [IDX_W-1:0] i;
    } mul_tag_t;

endpackage

### sv/adaline_mul.sv
// Shared signed multiplier with registered product and operation tag.
// Depends on adaline_pkg.
module adaline_mul
    import adaline_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [MA_W-1:0]   a,
    input  logic signed [MB_W-1:0]   b,
    input  mul_tag_t                 tag,
    output logic signed [PROD_W-1:0] prod_reg,
    output mul_tag_t                 tag_reg
);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

endmodule

### sv/adaline_lms_update_core.sv
// ADALINE LMS update top level: sequencer, weight/bias store, output register.
// Depends on adaline_pkg and adaline_mul.
// The result is valid after the forward pass when all errors are zero; otherwise a
// weight and bias update pass over every output follows before the result is shown.
// A new input is not taken until the previous result is loaded; every product goes through the one
// 25x17 multiplier. Async active-low reset clears weights, biases, FSM and sets rate to 655.
module adaline_lms_update_core
    import adaline_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [RATE_W-1:0]        cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [X_W-1:0]    x0,
    input  logic signed [X_W-1:0]    x1,
    input  logic signed [X_W-1:0]    x2,
    input  logic signed [X_W-1:0]    x3,
    input  logic signed [DATA_W-1:0] t0,
    input  logic signed [DATA_W-1:0] t1,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DATA_W-1:0] y0,
    output logic signed [DATA_W-1:0] y1,
    output logic signed [DATA_W-1:0] e0,
    output logic signed [DATA_W-1:0] e1,
    output logic                     changed
);

    localparam int YR_W = ACC_W + 1 - Y_SHIFT;
    localparam int BS_W = P_W + 1 - B_SHIFT;
    localparam int WD_W = ACCU_W - W_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD,
        S_DRAIN,
        S_FIN,
        S_ERR,
        S_DEC,
        S_RE,
        S_REWAIT,
        S_LO,
        S_HI,
        S_TAIL,
        S_DONE
    } state_t;

    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SAT_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[SAT_W-1:DATA_W-1] == {(SAT_W-DATA_W+1){v[DATA_W-1]}})
            r = v[DATA_W-1:0];
        else if (v[SAT_W-1])
            r = VAL_MIN;
        else
            r = VAL_MAX;
        return r;
    endfunction

    state_t state_reg, state_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [IDX_W-1:0] i_reg, i_next;

    logic [RATE_W-1:0] rate_reg;

    logic signed [X_W-1:0]    x_in [IN_DIM];
    logic signed [X_W-1:0]    x_reg [IN_DIM];
    logic signed [DATA_W-1:0] t_in [OUT_DIM];
    logic signed [DATA_W-1:0] t_reg [OUT_DIM];

    logic signed [DATA_W-1:0] w_reg [OUT_DIM][IN_DIM];
    logic signed [DATA_W-1:0] b_reg [OUT_DIM];

    logic signed [ACC_W-1:0]  acc_reg [OUT_DIM];
    logic signed [DATA_W-1:0] y_reg [OUT_DIM];
    logic signed [DATA_W-1:0] e_reg [OUT_DIM];
    logic                     chg_reg;

    logic signed [P_W-1:0]    p_reg;
    logic signed [BS_W-1:0]   bstep_reg;
    logic signed [ACCU_W-1:0] accu_reg;
    logic signed [DATA_W-1:0] wold_reg;
    logic                     wb_valid_reg;
    logic [N_W-1:0]           wb_n_reg;
    logic [IDX_W-1:0]         wb_i_reg;

    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] y0_reg, y1_reg, e0_reg, e1_reg;
    logic                     changed_reg;

    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    mul_tag_t                 mul_tag;
    logic signed [PROD_W-1:0] prod_reg;
    mul_tag_t                 mtag;

    logic signed [DATA_W-1:0] w_rd, e_rd, b_rd;
    logic signed [X_W-1:0]    x_rd;
    logic signed [ACC_W-1:0]  acc_init;
    logic signed [WX_W-1:0]   prod_wx;
    logic signed [ACCU_W-1:0] prod_x;
    logic signed [P_W-1:0]    prod_p;
    logic signed [P_W:0]      brnd;
    logic signed [WD_W-1:0]   wd;
    logic signed [WD_W:0]     wsum;
    logic signed [BS_W:0]     bsum;

    logic signed [ACC_W:0]    acc_rnd [OUT_DIM];
    logic signed [YR_W-1:0]   yr [OUT_DIM];
    logic signed [DATA_W:0]   ed [OUT_DIM];

    logic in_xfer, load_out, any_err, i_last, n_last;

    assign x_in[0] = x0;
    assign x_in[1] = x1;
    assign x_in[2] = x2;
    assign x_in[3] = x3;
    assign t_in[0] = t0;
    assign t_in[1] = t1;

    assign in_stall = (state_reg != S_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    assign i_last = (i_reg == IDX_W'(IN_DIM - 1));
    assign n_last = (n_reg == N_W'(OUT_DIM - 1));

    assign w_rd = w_reg[n_reg][i_reg];
    assign x_rd = x_reg[i_reg];
    assign e_rd = e_reg[n_reg];
    assign b_rd = b_reg[n_reg];

    assign acc_init = ACC_W'(b_rd) << Y_SHIFT;
    assign prod_wx  = prod_reg[WX_W-1:0];
    assign prod_x   = ACCU_W'(prod_reg);
    assign prod_p   = prod_reg[P_W-1:0];
    assign brnd     = (P_W+1)'(prod_p) + (P_W+1)'(1 << (B_SHIFT - 1));
    assign wd       = accu_reg[ACCU_W-1:W_SHIFT];
    assign wsum     = (WD_W+1)'(wd) + (WD_W+1)'(wold_reg);
    assign bsum     = (BS_W+1)'(bstep_reg) + (BS_W+1)'(b_rd);

    always_comb
    begin
        any_err = 1'b0;
        for (int k = 0; k < OUT_DIM; k++)
        begin
            acc_rnd[k] = (ACC_W+1)'(acc_reg[k]) + (ACC_W+1)'(1 << (Y_SHIFT - 1));
            yr[k]      = acc_rnd[k][ACC_W:Y_SHIFT];
            ed[k]      = (DATA_W+1)'(t_reg[k]) - (DATA_W+1)'(y_reg[k]);
            any_err    = any_err | (e_reg[k] != '0);
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_FWD;
                    n_next     = '0;
                    i_next     = '0;
                end
            end
            S_FWD:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (n_last)
                        state_next = S_DRAIN;
                    else
                        n_next = n_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            S_DRAIN:  state_next = S_FIN;
            S_FIN:    state_next = S_ERR;
            S_ERR:    state_next = S_DEC;
            S_DEC:
            begin
                n_next     = '0;
                i_next     = '0;
                state_next = any_err ? S_RE : S_DONE;
            end
            S_RE:     state_next = S_REWAIT;
            S_REWAIT: state_next = S_LO;
            S_LO:     state_next = S_HI;
            S_HI:
            begin
                if (i_last)
                begin
                    i_next = '0;
                    if (n_last)
                    begin
                        state_next = S_TAIL;
                    end
                    else
                    begin
                        n_next     = n_reg + 1'b1;
                        state_next = S_RE;
                    end
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_LO;
                end
            end
            S_TAIL:   state_next = S_DONE;
            S_DONE:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        mul_tag     = '0;
        mul_tag.n   = n_reg;
        mul_tag.i   = i_reg;
        case (state_reg)
            S_FWD:
            begin
                mul_a       = MA_W'(w_rd);
                mul_b       = MB_W'(x_rd);
                mul_tag.vld = 1'b1;
                mul_tag.op  = OP_MAC;
            end
            S_RE:
            begin
                mul_a       = MA_W'(e_rd);
                mul_b       = {1'b0, rate_reg};
                mul_tag.vld = 1'b1;
                mul_tag.op  = OP_RE;
            end
            S_LO:
            begin
                mul_a       = {{(MA_W-PL_W){1'b0}}, p_reg[PL_W-1:0]};
                mul_b       = MB_W'(x_rd);
                mul_tag.vld = 1'b1;
                mul_tag.op  = OP_LO;
            end
            S_HI:
            begin
                mul_a       = {{(MA_W-PH_W){p_reg[P_W-1]}}, p_reg[P_W-1:PL_W]};
                mul_b       = MB_W'(x_rd);
                mul_tag.vld = 1'b1;
                mul_tag.op  = OP_HI;
            end
            default:
            begin
                mul_tag.vld = 1'b0;
            end
        endcase
    end

    adaline_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .a        (mul_a),
        .b        (mul_b),
        .tag      (mul_tag),
        .prod_reg (prod_reg),
        .tag_reg  (mtag)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
            y0_reg        <= '0;
            y1_reg        <= '0;
            e0_reg        <= '0;
            e1_reg        <= '0;
            changed_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
            begin
                y0_reg      <= y_reg[0];
                y1_reg      <= y_reg[1];
                e0_reg      <= e_reg[0];
                e1_reg      <= e_reg[1];
                changed_reg <= chg_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rate_reg <= RATE_RESET;
        else if (cfg_we)
            rate_reg <= cfg_wdata;
    end

    // weight and bias store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < OUT_DIM; k++)
            begin
                b_reg[k] <= '0;
                for (int j = 0; j < IN_DIM; j++)
                    w_reg[k][j] <= '0;
            end
            wb_valid_reg <= 1'b0;
        end
        else
        begin
            wb_valid_reg <= mtag.vld && (mtag.op == OP_HI);
            if (wb_valid_reg)
                w_reg[wb_n_reg][wb_i_reg] <= sat_data(SAT_W'(wsum));
            if ((state_reg == S_LO) && (i_reg == '0))
                b_reg[n_reg] <= sat_data(SAT_W'(bsum));
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            for (int k = 0; k < IN_DIM; k++)
                x_reg[k] <= x_in[k];
            for (int k = 0; k < OUT_DIM; k++)
                t_reg[k] <= t_in[k];
        end

        if ((state_reg == S_FWD) && (i_reg == '0))
            acc_reg[n_reg] <= acc_init;

        if (state_reg == S_FIN)
        begin
            for (int k = 0; k < OUT_DIM; k++)
                y_reg[k] <= sat_data(SAT_W'(yr[k]));
        end

        if (state_reg == S_ERR)
        begin
            for (int k = 0; k < OUT_DIM; k++)
                e_reg[k] <= sat_data(SAT_W'(ed[k]));
        end

        if (state_reg == S_DEC)
            chg_reg <= any_err;

        if (state_reg == S_HI)
            wold_reg <= w_rd;

        wb_n_reg <= mtag.n;
        wb_i_reg <= mtag.i;

        if (mtag.vld)
        begin
            case (mtag.op)
                OP_MAC: acc_reg[mtag.n] <= acc_reg[mtag.n] + ACC_W'(prod_wx);
                OP_RE:
                begin
                    p_reg     <= prod_p;
                    bstep_reg <= brnd[P_W:B_SHIFT];
                end
                OP_LO:  accu_reg <= prod_x + ACCU_W'(1 << (W_SHIFT - 1));
                OP_HI:  accu_reg <= accu_reg + (prod_x << PL_W);
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign y0        = y0_reg;
    assign y1        = y1_reg;
    assign e0        = e0_reg;
    assign e1        = e1_reg;
    assign changed   = changed_reg;

endmodule

### sv/adaline_chk.sv
// Port-level checker for adaline_lms_update_core, bound to the top level.
// Depends on adaline_pkg.
module adaline_chk
    import adaline_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [DATA_W-1:0] y0,
    input logic signed [DATA_W-1:0] y1,
    input logic signed [DATA_W-1:0] e0,
    input logic signed [DATA_W-1:0] e1,
    input logic                     changed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(y0) && $stable(y1)
            && $stable(e0) && $stable(e1) && $stable(changed)))
        else $error("result changed while stalled");

    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken while an item is in work");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_valid) |=> !out_valid)
        else $error("result shown right after input transfer");

    a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (changed == ((e0 != '0) || (e1 != '0))))
        else $error("changed flag disagrees with errors");

endmodule

bind adaline_lms_update_core adaline_chk u_adaline_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .y0        (y0),
    .y1        (y1),
    .e0        (e0),
    .e1        (e1),
    .changed   (changed)
);
